// ===== rtl/core/cu32_pkg.sv =====
// ----------------------------------------------------------------------------
// Checked ALU package
// Operation and status codes shared by the checked 32-bit ALU modules.
// ----------------------------------------------------------------------------
package cu32_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 6;

  typedef enum logic [3:0] {
    OP_NOT  = 4'd0,
    OP_ADD  = 4'd1,
    OP_MUL  = 4'd2,
    OP_SUB  = 4'd3,
    OP_POW  = 4'd4,
    OP_DIV  = 4'd5,
    OP_REM  = 4'd6,
    OP_XOR  = 4'd7,
    OP_AND  = 4'd8,
    OP_OR   = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_DIVZERO  = 3'd2,
    ST_ZEROZERO = 3'd3,
    ST_INVALID  = 3'd4
  } status_e;

  // Request from the controller to the serial multiplier.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] mcand;
    logic [DataW-1:0] mplier;
  } mul_req_t;

  // Result of the serial multiplier.
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [DataW-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== rtl/core/cu32_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial checked multiplier
// Shift-and-add over one multiplier bit per cycle; flags a product above
// 32 bits.
// ----------------------------------------------------------------------------
module cu32_mul
  import cu32_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] mc_q, mc_d;
  logic [DataW-1:0] mp_q, mp_d;
  logic             mchi_q, mchi_d;
  logic             ovf_q, ovf_d;
  logic             done_q, done_d;
  logic [DataW:0]   sum;

  // Multiplicand shifts left each cycle; mchi_q records bits shifted out.
  assign sum = {1'b0, acc_q} + {1'b0, mc_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    mchi_d = mchi_q;
    ovf_d  = ovf_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      mc_d   = req_i.mcand;
      mp_d   = req_i.mplier;
      mchi_d = 1'b0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_d = sum[DataW-1:0];
        if (sum[DataW] || mchi_q) ovf_d = 1'b1;
      end
      mchi_d = mchi_q | mc_q[DataW-1];
      mc_d   = {mc_q[DataW-2:0], 1'b0};
      mp_d   = {1'b0, mp_q[DataW-1:1]};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    mc_q   <= mc_d;
    mp_q   <= mp_d;
    mchi_q <= mchi_d;
    ovf_q  <= ovf_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.prod = acc_q;

endmodule

// ===== rtl/core/cu32_div.sv =====
// ----------------------------------------------------------------------------
// Restoring serial divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module cu32_div
  import cu32_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quot_o,
  output logic [DataW-1:0] rem_o
);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] quo_q, rem_q, dvs_q;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  assign trial = {rem_q, quo_q[DataW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (diff[DataW]) begin
        rem_q <= trial[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end else begin
        rem_q <= diff[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/checked_uint32_alu_unit.sv =====
// ----------------------------------------------------------------------------
// Checked unsigned 32-bit ALU
// Sequential ALU with overflow, divide-by-zero, zero-to-the-zero and invalid-code checks.
// ----------------------------------------------------------------------------
// The slave channel takes one word per operation: opcode, left and right
// operand. The master channel returns one word per operation: a 32-bit value
// and a 3-bit status; the value is zero whenever the status is not ok.
// Not, add, subtract, xor, and and or present their result in the cycle after
// acceptance. Multiply runs on a bit-serial shift-and-add unit. Divide and
// remainder use a restoring divider, one quotient bit per cycle. Power walks
// the exponent from its low bit with serial multiplies, and stops at once on
// overflow.
// One operation is in flight at a time; s_axis_tready is high only when the
// unit holds no operation. A result waits in the output register while the
// receiver stalls, and the next word is taken in the cycle after delivery.
// Reset clears the control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module checked_uint32_alu_unit
  import cu32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: operation [3:0], left_operand [35:4], right_operand [67:36], zero pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: value [31:0], status [34:32], zero pad
  output logic [39:0] m_axis_tdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIV  = 6'b000100,
    S_PACC = 6'b001000,
    S_PSQ  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [3:0]       op_q, op_d;
  logic [DataW-1:0] a_q, a_d;     // power: squared base
  logic [DataW-1:0] b_q, b_d;     // power: remaining exponent
  logic [DataW-1:0] acc_q, acc_d; // power accumulator
  logic [DataW-1:0] val_q, val_d;
  status_e          st_q, st_d;
  logic             pend_q, pend_d; // a multiply is running

  mul_req_t         mreq;
  mul_rsp_t         mrsp;
  logic             dstart;
  logic             ddone;
  logic [DataW-1:0] dquot, drem;

  logic [3:0]       in_op;
  logic [DataW-1:0] in_a, in_b;
  logic [DataW:0]   add_w;
  logic [DataW:0]   sub_w;

  assign in_op = s_axis_tdata[3:0];
  assign in_a  = s_axis_tdata[35:4];
  assign in_b  = s_axis_tdata[67:36];
  assign add_w = {1'b0, in_a} + {1'b0, in_b};
  assign sub_w = {1'b0, in_a} - {1'b0, in_b};

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    val_d       = val_q;
    st_d        = st_q;
    pend_d      = 1'b0;
    mreq.start  = 1'b0;
    mreq.mcand  = a_q;
    mreq.mplier = a_q;
    dstart      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = in_op;
          a_d     = in_a;
          b_d     = in_b;
          acc_d   = DataW'(1);
          val_d   = '0;
          st_d    = ST_OK;
          state_d = S_OUT;
          case (in_op)
            OP_NOT: val_d = ~in_a;
            OP_ADD: begin
              if (add_w[DataW]) st_d = ST_OVERFLOW;
              else val_d = add_w[DataW-1:0];
            end
            OP_SUB: begin
              if (sub_w[DataW]) st_d = ST_OVERFLOW;
              else val_d = sub_w[DataW-1:0];
            end
            OP_XOR: val_d = in_a ^ in_b;
            OP_AND: val_d = DataW'((in_a != '0) && (in_b != '0));
            OP_OR:  val_d = DataW'((in_a != '0) || (in_b != '0));
            OP_MUL: begin
              mreq.start  = 1'b1;
              mreq.mcand  = in_a;
              mreq.mplier = in_b;
              state_d     = S_MUL;
            end
            OP_DIV, OP_REM: begin
              if (in_b == '0) st_d = ST_DIVZERO;
              else begin
                dstart  = 1'b1;
                state_d = S_DIV;
              end
            end
            OP_POW: begin
              if (in_a == '0 && in_b == '0) st_d = ST_ZEROZERO;
              else state_d = S_PACC;
            end
            default: st_d = ST_INVALID;
          endcase
        end
      end
      S_MUL: begin
        if (mrsp.done) begin
          if (mrsp.ovf) st_d = ST_OVERFLOW;
          else val_d = mrsp.prod;
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (ddone) begin
          val_d   = (op_q == OP_DIV) ? dquot : drem;
          state_d = S_OUT;
        end
      end
      S_PACC: begin
        // Multiply the accumulator by the square when the exponent bit is set; finish when no exponent bits remain.
        mreq.mcand  = acc_q;
        mreq.mplier = a_q;
        if (!pend_q) begin
          if (b_q == '0) begin
            val_d   = acc_q;
            state_d = S_OUT;
          end else if (b_q[0]) begin
            mreq.start = 1'b1;
            pend_d     = 1'b1;
          end else begin
            b_d     = {1'b0, b_q[DataW-1:1]};
            state_d = S_PSQ;
          end
        end else if (mrsp.done) begin
          if (mrsp.ovf) begin
            st_d    = ST_OVERFLOW;
            state_d = S_OUT;
          end else begin
            acc_d   = mrsp.prod;
            b_d     = {1'b0, b_q[DataW-1:1]};
            state_d = S_PSQ;
          end
        end else pend_d = 1'b1;
      end
      S_PSQ: begin
        // Square the base only while exponent bits remain.
        if (!pend_q) begin
          if (b_q == '0) begin
            val_d   = acc_q;
            state_d = S_OUT;
          end else begin
            mreq.start = 1'b1;
            pend_d     = 1'b1;
          end
        end else if (mrsp.done) begin
          if (mrsp.ovf) begin
            st_d    = ST_OVERFLOW;
            state_d = S_OUT;
          end else begin
            a_d     = mrsp.prod;
            state_d = S_PACC;
          end
        end else pend_d = 1'b1;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    val_q <= val_d;
    st_q  <= st_d;
  end

  cu32_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  cu32_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dstart),
    .dividend_i (in_a),
    .divisor_i  (in_b),
    .done_o     (ddone),
    .quot_o     (dquot),
    .rem_o      (drem)
  );

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {5'b0, st_q, val_q};

`ifndef SYNTH
  // A non-ok status always carries a zero value.
  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st_q != ST_OK) |-> (val_q == '0))
    else $error("non-ok result carries a value");

  // No new word is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result pending");

  // The multiplier is never restarted while a multiply is pending.
  a_mul_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !mrsp.done |-> !mreq.start)
    else $error("multiplier restarted while busy");
`endif

endmodule
